FILE: design/csv_tok_pkg.sv
// ----------------------------------------------------------------------------
// csv_tok_pkg
// Shared types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csv_tok_pkg;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIM = 1'b0,
    CFG_QUOTE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_SKIP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PS_START  = 2'd0,
    PS_PLAIN  = 2'd1,
    PS_QUOTED = 2'd2,
    PS_AFTERQ = 2'd3
  } parse_state_e;

  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] quote;
  } cfg_t;

  typedef struct packed {
    parse_state_e ps;
    logic         after_cr;
    logic         skip_pending;
    logic         field_has_data;
    logic         row_has_fields;
  } tok_state_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       field_end;
    logic       row_end;
    logic       drop_row;
    logic       unterminated_quote;
  } result_t;

endpackage

FILE: design/csv_tok_cfg.sv
// ----------------------------------------------------------------------------
// csv_tok_cfg
// Configuration registers: delimiter and quote bytes.
// ----------------------------------------------------------------------------
module csv_tok_cfg (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_en_i,
  input  logic [csv_tok_pkg::CFG_IDX_W-1:0]      wr_index_i,
  input  logic [7:0]                             wr_data_i,
  output csv_tok_pkg::cfg_t                      cfg_o
);
  import csv_tok_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CFG_DELIM: cfg_d.delim = wr_data_i;
        CFG_QUOTE: cfg_d.quote = wr_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim <= DELIM_RESET;
      cfg_q.quote <= QUOTE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/csv_tok_step.sv
// ----------------------------------------------------------------------------
// csv_tok_step
// Per-item decision logic: classifies one command/byte against the parser
// state and produces the next state and at most one result.
// ----------------------------------------------------------------------------
module csv_tok_step (
  input  logic [1:0]              cmd_i,
  input  logic [7:0]              data_byte_i,
  input  csv_tok_pkg::cfg_t       cfg_i,
  input  csv_tok_pkg::tok_state_t state_i,
  output csv_tok_pkg::tok_state_t state_o,
  output csv_tok_pkg::result_t    res_o,
  output logic                    res_valid_o
);
  import csv_tok_pkg::*;

  logic is_q;
  logic is_d;
  logic is_nl;
  logic act_content;
  logic act_field;
  logic act_row;

  assign is_q  = (data_byte_i == cfg_i.quote);
  assign is_d  = (data_byte_i == cfg_i.delim);
  assign is_nl = (data_byte_i == CH_CR) || (data_byte_i == CH_LF);

  always_comb begin
    state_o     = state_i;
    res_o       = '0;
    res_valid_o = 1'b0;
    act_content = 1'b0;
    act_field   = 1'b0;
    act_row     = 1'b0;

    case (cmd_i)
      CMD_SKIP: begin
        state_o.skip_pending = 1'b1;
      end

      CMD_FLUSH: begin
        state_o.after_cr = 1'b0;
        if (state_i.ps == PS_QUOTED) begin
          // abandon the partial row, keep any pending skip
          state_o.ps                 = PS_START;
          state_o.field_has_data     = 1'b0;
          state_o.row_has_fields     = 1'b0;
          res_o.unterminated_quote   = 1'b1;
          res_valid_o                = 1'b1;
        end else if (!(state_i.ps == PS_START && !state_i.row_has_fields &&
                       !state_i.field_has_data)) begin
          act_row = 1'b1;
        end
      end

      CMD_DATA: begin
        state_o.after_cr = 1'b0;
        // drop the LF of a CRLF pair
        if (!(state_i.after_cr && data_byte_i == CH_LF)) begin
          case (state_i.ps)
            PS_START: begin
              if (is_q) begin
                state_o.ps             = PS_QUOTED;
                state_o.field_has_data = 1'b1;
              end else if (is_d) begin
                act_field = 1'b1;
              end else if (is_nl) begin
                act_row = 1'b1;
              end else begin
                state_o.ps  = PS_PLAIN;
                act_content = 1'b1;
              end
            end
            PS_PLAIN: begin
              if (is_d) begin
                act_field = 1'b1;
              end else if (is_nl) begin
                act_row = 1'b1;
              end else begin
                act_content = 1'b1;
              end
            end
            PS_QUOTED: begin
              if (is_q) begin
                state_o.ps = PS_AFTERQ;
              end else begin
                act_content = 1'b1;
              end
            end
            default: begin
              if (is_q) begin
                // doubled quote is a literal quote
                state_o.ps  = PS_QUOTED;
                act_content = 1'b1;
              end else if (is_d) begin
                act_field = 1'b1;
              end else if (is_nl) begin
                act_row = 1'b1;
              end else begin
                state_o.ps  = PS_PLAIN;
                act_content = 1'b1;
              end
            end
          endcase
          if (act_row) begin
            state_o.after_cr = (data_byte_i == CH_CR);
          end
        end
      end

      default: begin
        state_o = state_i;
      end
    endcase

    if (act_content) begin
      state_o.field_has_data = 1'b1;
      res_o.has_byte         = 1'b1;
      res_o.out_byte         = data_byte_i;
      res_valid_o            = 1'b1;
    end
    if (act_field) begin
      state_o.field_has_data = 1'b0;
      state_o.row_has_fields = 1'b1;
      state_o.ps             = PS_START;
      res_o.field_end        = 1'b1;
      res_valid_o            = 1'b1;
    end
    if (act_row) begin
      state_o.skip_pending   = 1'b0;
      state_o.field_has_data = 1'b0;
      state_o.row_has_fields = 1'b0;
      state_o.ps             = PS_START;
      res_o.field_end        = 1'b1;
      res_o.row_end          = 1'b1;
      res_o.drop_row         = state_i.skip_pending;
      res_valid_o            = 1'b1;
    end
  end

endmodule

FILE: design/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Byte-serial CSV tokenizer with configurable delimiter and quote bytes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid_i/in_ready_o  | cmd_i, data_byte_i
//  out     | source    | out_valid_o/out_ready_i| has_byte_o, out_byte_o,
//          |           |                        | field_end_o, row_end_o,
//          |           |                        | drop_row_o, unterminated_quote_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One word per cycle sustained while the output is not stalled. A word is
//  latched in the input register, decided against the parser state, and
//  then written into the output register. Words that yield no result leave no
//  output. The input register keeps accepting while a result waits, until
//  both registers are full and the output is stalled. Reset clears all
//  control state and loads the delimiter ',' and quote '"'.
// ----------------------------------------------------------------------------
module csv_field_tokenizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         cmd_i,
  input  logic [7:0]                         data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               has_byte_o,
  output logic [7:0]                         out_byte_o,
  output logic                               field_end_o,
  output logic                               row_end_o,
  output logic                               drop_row_o,
  output logic                               unterminated_quote_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [csv_tok_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [7:0]                         cfg_data_i
);
  import csv_tok_pkg::*;

  cfg_t       cfg;
  tok_state_t st_q;
  tok_state_t st_d;
  tok_state_t st_next;
  result_t    res;
  logic       res_valid;
  result_t    out_q;
  result_t    out_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       in_valid_q;
  logic       in_valid_d;
  logic [1:0] cmd_q;
  logic [1:0] cmd_d;
  logic [7:0] byte_q;
  logic [7:0] byte_d;
  logic       advance;
  logic       in_fire;

  assign cfg_ready_o = 1'b1;

  csv_tok_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  csv_tok_step u_step (
    .cmd_i       (cmd_q),
    .data_byte_i (byte_q),
    .cfg_i       (cfg),
    .state_i     (st_q),
    .state_o     (st_next),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  // process the held word when the output register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    cmd_d      = cmd_q;
    byte_d     = byte_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
      cmd_d      = cmd_i;
      byte_d     = data_byte_i;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    st_d        = advance ? st_next : st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance && res_valid) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{ps: PS_START, default: 1'b0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  assign out_valid_o          = out_valid_q;
  assign has_byte_o           = out_q.has_byte;
  assign out_byte_o           = out_q.out_byte;
  assign field_end_o          = out_q.field_end;
  assign row_end_o            = out_q.row_end;
  assign drop_row_o           = out_q.drop_row;
  assign unterminated_quote_o = out_q.unterminated_quote;

  a_row_has_field_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_end_o |-> field_end_o)
    else $error("row end without field end");

  a_drop_only_at_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drop_row_o |-> row_end_o)
    else $error("drop mark outside a row end");

  a_uq_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unterminated_quote_o |-> !has_byte_o && !field_end_o)
    else $error("unterminated quote combined with other marks");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with room available");

  a_state_holds_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> st_q == $past(st_q))
    else $error("parser state moved without a word");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CSV field tokenizer. A table of hand-picked
// words with typed expectations covers the parser corners under the reset
// delimiter and quote. Random CSV-like traffic then runs under several
// delimiter/quote settings, checked against a cycle-free token predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csv_tok_pkg::*;

  localparam logic [1:0] CMD_RSVD    = 2'd3;
  localparam int         PHASES      = 7;
  localparam int         PHASE_WORDS = 110;
  localparam int         SETTLE      = 6;

  // How a table row states its expectation: from the predictor or typed in.
  typedef enum logic [2:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_BYTE,
    EXP_FIELD,
    EXP_ROW,
    EXP_DROPPED,
    EXP_UNTERM
  } row_exp_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    row_exp_e   kind;
  } word_row_t;

  localparam word_row_t SCRIPT [30] = '{
    '{CMD_FLUSH, 8'h00,       EXP_NONE},     // flush with nothing open
    '{CMD_DATA,  8'h00,       EXP_BYTE},
    '{CMD_DATA,  8'hFF,       EXP_BYTE},
    '{CMD_DATA,  DELIM_RESET, EXP_FIELD},
    '{CMD_DATA,  QUOTE_RESET, EXP_NONE},     // open a quoted field
    '{CMD_DATA,  CH_CR,       EXP_BYTE},     // CR is content inside quotes
    '{CMD_DATA,  QUOTE_RESET, EXP_NONE},
    '{CMD_DATA,  QUOTE_RESET, EXP_BYTE},     // doubled quote
    '{CMD_DATA,  DELIM_RESET, EXP_BYTE},
    '{CMD_DATA,  QUOTE_RESET, EXP_NONE},
    '{CMD_DATA,  8'h78,       EXP_BYTE},     // text after closing quote
    '{CMD_DATA,  QUOTE_RESET, EXP_BYTE},     // quote in unquoted field
    '{CMD_SKIP,  8'hFF,       EXP_NONE},
    '{CMD_SKIP,  8'h00,       EXP_NONE},     // skips do not add up
    '{CMD_DATA,  CH_CR,       EXP_DROPPED},
    '{CMD_DATA,  CH_LF,       EXP_NONE},     // LF of CRLF swallowed
    '{CMD_DATA,  CH_LF,       EXP_ROW},      // empty line
    '{CMD_DATA,  8'h61,       EXP_BYTE},
    '{CMD_DATA,  DELIM_RESET, EXP_FIELD},
    '{CMD_FLUSH, 8'h00,       EXP_ROW},      // trailing empty field
    '{CMD_DATA,  QUOTE_RESET, EXP_NONE},
    '{CMD_DATA,  8'h71,       EXP_BYTE},
    '{CMD_DATA,  QUOTE_RESET, EXP_NONE},
    '{CMD_FLUSH, 8'h00,       EXP_ROW},      // closing quote right before flush
    '{CMD_DATA,  QUOTE_RESET, EXP_NONE},
    '{CMD_FLUSH, 8'h00,       EXP_UNTERM},
    '{CMD_RSVD,  8'hFF,       EXP_NONE},
    '{CMD_DATA,  CH_CR,       EXP_ROW},
    '{CMD_FLUSH, 8'h00,       EXP_NONE},     // flush clears pending CR
    '{CMD_DATA,  CH_LF,       EXP_ROW}
  };

  localparam logic [7:0] PHASE_DELIM [PHASES] =
    '{DELIM_RESET, 8'h00, 8'hFF, 8'h27, CH_LF, DELIM_RESET, 8'h00};
  localparam logic [7:0] PHASE_QUOTE [PHASES] =
    '{QUOTE_RESET, 8'hFF, 8'h00, 8'h27, CH_CR, QUOTE_RESET, 8'h00};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [1:0] in_cmd = CMD_DATA;
  logic [7:0] in_data = 8'h00;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  cfg_idx_e   cfg_index = CFG_DELIM;
  logic [7:0] cfg_data = 8'h00;

  logic       in_ready, out_valid, cfg_ready;
  logic       has_byte, field_end, row_end, drop_row, unterm_quote;
  logic [7:0] out_byte;

  // token predictor state
  parse_state_e tk_state = PS_START;
  bit           tk_after_cr = 1'b0;
  bit           tk_skip_pending = 1'b0;
  bit           tk_field_data = 1'b0;
  bit           tk_row_fields = 1'b0;
  logic [7:0]   cur_delim = DELIM_RESET;
  logic [7:0]   cur_quote = QUOTE_RESET;

  result_t token_q [$];
  int          fail_count = 0;
  int          burst_left = 0;
  logic [9:0]  tick = '0;

  csv_field_tokenizer dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .cmd_i                (in_cmd),
    .data_byte_i          (in_data),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .has_byte_o           (has_byte),
    .out_byte_o           (out_byte),
    .field_end_o          (field_end),
    .row_end_o            (row_end),
    .drop_row_o           (drop_row),
    .unterminated_quote_o (unterm_quote),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void add_content(input logic [7:0] c, output result_t res);
    tk_field_data = 1'b1;
    res = '0;
    res.has_byte = 1'b1;
    res.out_byte = c;
  endfunction

  function automatic void close_field(output result_t res);
    tk_field_data = 1'b0;
    tk_row_fields = 1'b1;
    tk_state = PS_START;
    res = '0;
    res.field_end = 1'b1;
  endfunction

  function automatic void close_row(input bit by_cr, output result_t res);
    tk_after_cr = by_cr;
    res = '0;
    res.field_end = 1'b1;
    res.row_end = 1'b1;
    res.drop_row = tk_skip_pending;
    tk_skip_pending = 1'b0;
    tk_field_data = 1'b0;
    tk_row_fields = 1'b0;
    tk_state = PS_START;
  endfunction

  // Advance the parser by one word; return 1 when the word yields a token.
  function automatic bit tokenize_word(input logic [1:0] cmd, input logic [7:0] c,
                                       output result_t res);
    logic nl;
    res = '0;
    nl = (c == CH_CR) || (c == CH_LF);
    case (cmd)
      CMD_SKIP: begin
        tk_skip_pending = 1'b1;
        return 1'b0;
      end
      CMD_FLUSH: begin
        tk_after_cr = 1'b0;
        if (tk_state == PS_QUOTED) begin
          tk_state = PS_START;
          tk_field_data = 1'b0;
          tk_row_fields = 1'b0;
          res.unterminated_quote = 1'b1;
          return 1'b1;
        end
        if (tk_state == PS_START && !tk_row_fields && !tk_field_data) return 1'b0;
        close_row(1'b0, res);
        return 1'b1;
      end
      CMD_DATA: begin
        if (tk_after_cr) begin
          tk_after_cr = 1'b0;
          if (c == CH_LF) return 1'b0;
        end
        case (tk_state)
          PS_START: begin
            if (c == cur_quote) begin
              tk_state = PS_QUOTED;
              tk_field_data = 1'b1;
              return 1'b0;
            end else if (c == cur_delim) close_field(res);
            else if (nl) close_row(c == CH_CR, res);
            else begin
              tk_state = PS_PLAIN;
              add_content(c, res);
            end
          end
          PS_PLAIN: begin
            if (c == cur_delim) close_field(res);
            else if (nl) close_row(c == CH_CR, res);
            else add_content(c, res);
          end
          PS_QUOTED: begin
            if (c == cur_quote) begin
              tk_state = PS_AFTERQ;
              return 1'b0;
            end
            add_content(c, res);
          end
          default: begin
            if (c == cur_quote) begin
              tk_state = PS_QUOTED;
              add_content(c, res);
            end else if (c == cur_delim) close_field(res);
            else if (nl) close_row(c == CH_CR, res);
            else begin
              tk_state = PS_PLAIN;
              add_content(c, res);
            end
          end
        endcase
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Send one word in bursts; on acceptance, queue what it should produce.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] data,
                           input row_exp_e kind);
    result_t predicted;
    result_t typed;
    bit      yields;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_data  <= data;
    do @(posedge clk); while (!in_ready);
    yields = tokenize_word(cmd, data, predicted);
    typed = '0;
    case (kind)
      EXP_MODEL:   if (yields) token_q = {token_q, predicted};
      EXP_NONE:    ;
      EXP_BYTE: begin
        typed.has_byte = 1'b1;
        typed.out_byte = data;
      end
      EXP_FIELD:   typed.field_end = 1'b1;
      EXP_ROW:     {typed.field_end, typed.row_end} = 2'b11;
      EXP_DROPPED: {typed.field_end, typed.row_end, typed.drop_row} = 3'b111;
      default:     typed.unterminated_quote = 1'b1;
    endcase
    if (kind != EXP_MODEL && kind != EXP_NONE) token_q = {token_q, typed};
  endtask

  // Hold the sender until every token is back and the pipe has settled.
  task automatic drain_tokens();
    in_valid <= 1'b0;
    burst_left = 0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_chars(input logic [7:0] delim, input logic [7:0] quote);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DELIM;
    cfg_data  <= delim;
    do @(posedge clk); while (!cfg_ready);
    cur_delim = delim;
    cfg_index <= CFG_QUOTE;
    cfg_data  <= quote;
    do @(posedge clk); while (!cfg_ready);
    cur_quote = quote;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Receiver: ready rate is set by tick[9:7].
  always @(posedge clk) begin
    tick <= tick + 1'b1;
    case (tick[9:7])
      3'd0, 3'd4: out_ready <= 1'b1;
      3'd1:       out_ready <= ($urandom_range(0, 99) < 75);
      3'd2, 3'd6: out_ready <= ($urandom_range(0, 99) < 40);
      3'd3:       out_ready <= ($urandom_range(0, 99) < 10);
      default:    out_ready <= tick[2] ^ tick[0];
    endcase
  end

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {has_byte, out_byte, field_end, row_end, drop_row, unterm_quote};
      if (token_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected token, expected none, actual %0h", $time, seen);
      end else begin
        want = token_q.pop_front();
        check_field("has_byte", 8'(want.has_byte), 8'(seen.has_byte));
        check_field("out_byte", want.out_byte, seen.out_byte);
        check_field("field_end", 8'(want.field_end), 8'(seen.field_end));
        check_field("row_end", 8'(want.row_end), 8'(seen.row_end));
        check_field("drop_row", 8'(want.drop_row), 8'(seen.drop_row));
        check_field("unterminated_quote", 8'(want.unterminated_quote),
                    8'(seen.unterminated_quote));
      end
    end
  end

  initial begin
    int          r;
    int          pause_at;
    logic [1:0]  cmd;
    logic [7:0]  data;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (SCRIPT[i]) send_word(SCRIPT[i].cmd, SCRIPT[i].data, SCRIPT[i].kind);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain_tokens();
        if (p == PHASES - 1) begin
          write_chars(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else begin
          write_chars(PHASE_DELIM[p], PHASE_QUOTE[p]);
        end
        @(posedge clk);
      end
      pause_at = $urandom_range(10, PHASE_WORDS - 10);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == pause_at) drain_tokens();
        r    = $urandom_range(0, 99);
        cmd  = CMD_DATA;
        data = 8'($urandom_range(0, 255));
        if (r < 3) cmd = CMD_FLUSH;
        else if (r < 5) cmd = CMD_SKIP;
        else if (r < 6) cmd = CMD_RSVD;
        else if (r < 22) data = cur_delim;
        else if (r < 38) data = cur_quote;
        else if (r < 46) data = CH_CR;
        else if (r < 52) data = CH_LF;
        else if (r < 75) data = 8'($urandom_range(8'h61, 8'h7A));
        send_word(cmd, data, EXP_MODEL);
      end
    end

    drain_tokens();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
